FILE: hdl/stt_pkg.sv
`timescale 1ns / 1ps
package stt_pkg;

  localparam int unsigned TokenLimit = 1024;
  localparam int unsigned TextLimit  = 63;
  localparam int unsigned NumKw      = 12;
  localparam int unsigned TokCntW    = $clog2(TokenLimit + 1);
  localparam int unsigned SpanW      = $clog2(TextLimit + 2);

  localparam logic [19:0] LineMax = 20'hFFFFF;
  localparam logic [23:0] PosMax  = 24'hFFFFFF;
  localparam logic [30:0] ValMax  = 31'h7FFFFFFF;

  localparam logic [5:0] KindId        = 6'd12;
  localparam logic [5:0] KindInt       = 6'd13;
  localparam logic [5:0] KindReal      = 6'd14;
  localparam logic [5:0] KindStr       = 6'd15;
  localparam logic [5:0] KindComma     = 6'd16;
  localparam logic [5:0] KindColon     = 6'd17;
  localparam logic [5:0] KindSemi      = 6'd18;
  localparam logic [5:0] KindLpar      = 6'd19;
  localparam logic [5:0] KindRpar      = 6'd20;
  localparam logic [5:0] KindAssign    = 6'd21;
  localparam logic [5:0] KindEqual     = 6'd22;
  localparam logic [5:0] KindAdd       = 6'd23;
  localparam logic [5:0] KindSub       = 6'd24;
  localparam logic [5:0] KindMul       = 6'd25;
  localparam logic [5:0] KindDiv       = 6'd26;
  localparam logic [5:0] KindNot       = 6'd27;
  localparam logic [5:0] KindNoteq     = 6'd28;
  localparam logic [5:0] KindLess      = 6'd29;
  localparam logic [5:0] KindGreater   = 6'd30;
  localparam logic [5:0] KindGreatereq = 6'd31;
  localparam logic [5:0] KindFinish    = 6'd32;

  localparam logic [2:0] ErrNone     = 3'd0;
  localparam logic [2:0] ErrUnknown  = 3'd1;
  localparam logic [2:0] ErrQuote    = 3'd2;
  localparam logic [2:0] ErrFraction = 3'd3;
  localparam logic [2:0] ErrLong     = 3'd4;
  localparam logic [2:0] ErrCount    = 3'd5;

  typedef enum logic [9:0] {
    M_IDLE    = 10'b0000000001,
    M_COMMENT = 10'b0000000010,
    M_STRING  = 10'b0000000100,
    M_INT     = 10'b0000001000,
    M_DOT     = 10'b0000010000,
    M_FRAC    = 10'b0000100000,
    M_IDENT   = 10'b0001000000,
    M_EQ      = 10'b0010000000,
    M_BANG    = 10'b0100000000,
    M_GT      = 10'b1000000000
  } mode_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [2:0]  error_code;
    logic [19:0] line_number;
    logic [30:0] int_value;
    logic [23:0] text_start;
    logic [5:0]  text_length;
    logic [7:0]  bad_char;
    logic        last_of_run;
  } out_item_t;

  // Classified byte handed from the front part to the back part.
  typedef struct packed {
    logic [7:0]  ch;
    logic        eot;
    logic [23:0] pos;
    logic        is_digit;
    logic        is_alpha;
    logic        is_blank;
  } cls_item_t;

  typedef logic [NumKw-1:0] kw_mask_t;

  // Keyword character at a given index, 0 when past the keyword's end.
  function automatic logic [7:0] kw_char(input int unsigned k, input int unsigned i);
    logic [8*8-1:0] s;
    int unsigned    n;
    unique case (k)
      0:  begin s = "int";      n = 3; end
      1:  begin s = "real";     n = 4; end
      2:  begin s = "str";      n = 3; end
      3:  begin s = "var";      n = 3; end
      4:  begin s = "if";       n = 2; end
      5:  begin s = "else";     n = 4; end
      6:  begin s = "while";    n = 5; end
      7:  begin s = "return";   n = 6; end
      8:  begin s = "function"; n = 8; end
      9:  begin s = "end";      n = 3; end
      10: begin s = "and";      n = 3; end
      default: begin s = "or";  n = 2; end
    endcase
    if (i >= n) return 8'd0;
    return s[8*(n-1-i) +: 8];
  endfunction

  function automatic int unsigned kw_len(input int unsigned k);
    unique case (k)
      0, 2, 3, 9, 10: return 3;
      1, 5:           return 4;
      4, 11:          return 2;
      6:              return 5;
      7:              return 6;
      default:        return 8;
    endcase
  endfunction

endpackage

FILE: hdl/stt_front.sv
`timescale 1ns / 1ps
module stt_front
  import stt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_data,
  output logic      q_push,
  input  logic      q_full,
  output cls_item_t q_data
);

  logic [23:0] pos_r, pos_nxt;
  logic        acc;

  assign in_full = q_full;
  assign acc     = in_push && !q_full;
  assign q_push  = acc;

  always_comb begin
    q_data          = '0;
    q_data.ch       = in_data.char_code;
    q_data.eot      = in_data.end_of_text;
    q_data.pos      = pos_r;
    q_data.is_digit = in_data.char_code >= "0" && in_data.char_code <= "9";
    q_data.is_alpha = (in_data.char_code >= "a" && in_data.char_code <= "z") ||
                      (in_data.char_code >= "A" && in_data.char_code <= "Z") ||
                      in_data.char_code == "_";
    q_data.is_blank = in_data.char_code == " " || in_data.char_code == 8'd9 ||
                      in_data.char_code == 8'd13;
    pos_nxt = pos_r;
    if (acc && !in_data.end_of_text && pos_r != PosMax) begin
      pos_nxt = pos_r + 24'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

FILE: hdl/stt_queue.sv
`timescale 1ns / 1ps
module stt_queue
  import stt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  cls_item_t wdata,
  input  logic      pop,
  output logic      empty,
  output cls_item_t rdata
);

  cls_item_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push && !full) - 2'(pop && !empty);
    end
  end

endmodule

FILE: hdl/stt_back.sv
`timescale 1ns / 1ps
module stt_back
  import stt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  output logic      q_pop,
  input  cls_item_t q_data,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  mode_t             mode_r, mode_nxt;
  logic [19:0]       line_r, line_nxt;
  logic [TokCntW-1:0] tcnt_r, tcnt_nxt;
  logic [30:0]       acc_r, acc_nxt;
  logic [23:0]       sst_r, sst_nxt;
  logic [SpanW-1:0]  slen_r, slen_nxt;
  kw_mask_t          kw_r, kw_nxt;
  logic              halt_r, halt_nxt;

  // Two-entry result buffer.
  out_item_t  rb_r [2];
  logic       rwp_r, rrp_r;
  logic [1:0] rcnt_r;

  out_item_t res [2];
  logic [1:0] nres;
  logic       take;
  logic [34:0] mul;

  assign out_empty = rcnt_r == 2'd0;
  assign out_data  = rb_r[rrp_r];
  assign take      = !q_empty && rcnt_r == 2'd0 || !q_empty && rcnt_r == 2'd1 && out_pop;
  assign q_pop     = take;
  assign mul       = {acc_r, 3'b000} + {2'b00, acc_r, 1'b0} + 35'(q_data.ch - 8'd48);

  always_comb begin
    logic [7:0]  c;
    logic        pend, restart, done;
    logic [5:0]  kind;
    c = q_data.ch;
    mode_nxt = mode_r; line_nxt = line_r; tcnt_nxt = tcnt_r; acc_nxt = acc_r;
    sst_nxt = sst_r; slen_nxt = slen_r; kw_nxt = kw_r; halt_nxt = halt_r;
    res[0] = '0; res[1] = '0; nres = 2'd0;
    pend = 1'b0; restart = 1'b0; done = 1'b0; kind = '0;

    if (!halt_r) begin
      // Current mode's handling of the byte; pend means flush, restart means rescan the byte.
      if (q_data.eot) begin
        pend = 1'b1;
      end else begin
        unique case (mode_r)
          M_COMMENT: if (c == 8'd10) begin
            mode_nxt = M_IDLE;
            if (line_r != LineMax) line_nxt = line_r + 20'd1;
          end
          M_STRING: if (c == "\"") begin
            mode_nxt = M_IDLE; pend = 1'b1; done = 1'b1;
          end else if (slen_r <= SpanW'(TextLimit)) slen_nxt = slen_r + 1'b1;
          M_INT: if (q_data.is_digit) begin
            acc_nxt = (mul > 35'(ValMax)) ? ValMax : mul[30:0];
            if (slen_r <= SpanW'(TextLimit)) slen_nxt = slen_r + 1'b1;
          end else if (c == ".") begin
            mode_nxt = M_DOT;
            if (slen_r <= SpanW'(TextLimit)) slen_nxt = slen_r + 1'b1;
          end else begin pend = 1'b1; restart = 1'b1; end
          M_DOT: if (q_data.is_digit) begin
            mode_nxt = M_FRAC;
            if (slen_r <= SpanW'(TextLimit)) slen_nxt = slen_r + 1'b1;
          end else begin pend = 1'b1; end
          M_FRAC: if (q_data.is_digit) begin
            if (slen_r <= SpanW'(TextLimit)) slen_nxt = slen_r + 1'b1;
          end else begin pend = 1'b1; restart = 1'b1; end
          M_IDENT: if (q_data.is_digit || q_data.is_alpha) begin
            for (int k = 0; k < NumKw; k++) begin
              if (int'(slen_r) >= kw_len(k) || kw_char(k, int'(slen_r)) != c)
                kw_nxt[k] = 1'b0;
            end
            if (slen_r <= SpanW'(TextLimit)) slen_nxt = slen_r + 1'b1;
          end else begin pend = 1'b1; restart = 1'b1; end
          M_EQ, M_BANG, M_GT: if (c == "=") begin
            mode_nxt = M_IDLE; pend = 1'b1; done = 1'b1;
          end else begin pend = 1'b1; restart = 1'b1; end
          default: restart = 1'b1;
        endcase
      end

      // Flush of a pending token.
      if (pend && mode_r != M_IDLE && mode_r != M_COMMENT) begin
        if (!done) mode_nxt = M_IDLE;
        unique case (mode_r)
          M_DOT: begin res[0].error_code = ErrFraction; halt_nxt = 1'b1; end
          M_STRING: if (!done) begin
            res[0].error_code = ErrQuote; halt_nxt = 1'b1;
          end else kind = KindStr;
          M_INT:   kind = KindInt;
          M_FRAC:  kind = KindReal;
          M_IDENT: begin
            kind = KindId;
            for (int k = 0; k < NumKw; k++) begin
              if (kw_r[k] && int'(slen_r) == kw_len(k)) kind = 6'(k);
            end
          end
          M_EQ:    kind = done ? KindEqual : KindAssign;
          M_BANG:  kind = done ? KindNoteq : KindNot;
          default: kind = done ? KindGreatereq : KindGreater;
        endcase
        if (!halt_nxt) begin
          if (mode_r == M_IDENT && slen_r > SpanW'(TextLimit)) begin
            res[0].error_code = ErrLong; halt_nxt = 1'b1;
          end else if (tcnt_r >= TokCntW'(TokenLimit)) begin
            res[0].error_code = ErrCount; halt_nxt = 1'b1;
          end else if ((mode_r == M_INT || mode_r == M_FRAC || mode_r == M_STRING) &&
                       slen_r > SpanW'(TextLimit)) begin
            res[0].error_code = ErrLong; halt_nxt = 1'b1;
          end else begin
            tcnt_nxt = tcnt_r + 1'b1;
            res[0].token_kind = kind;
            if (kind == KindInt) res[0].int_value = acc_r;
            if (kind == KindInt || kind == KindReal || kind == KindStr || kind == KindId) begin
              res[0].text_start  = sst_r;
              res[0].text_length = 6'(slen_r);
            end
          end
        end
        if (halt_nxt) begin res[0].token_kind = KindFinish; mode_nxt = M_IDLE; end
        res[0].line_number = line_r;
        nres = 2'd1;
      end

      // End of text: finish token.
      if (q_data.eot && !halt_nxt) begin
        if (tcnt_nxt >= TokCntW'(TokenLimit)) res[nres[0]].error_code = ErrCount;
        else tcnt_nxt = tcnt_nxt + 1'b1;
        res[nres[0]].token_kind  = KindFinish;
        res[nres[0]].line_number = line_r;
        nres = nres + 2'd1;
        halt_nxt = 1'b1;
      end

      // Start of a new token from the byte.
      if (restart && !q_data.eot && !halt_nxt) begin
        mode_nxt = M_IDLE; kind = '0;
        if (q_data.is_blank) begin
        end else if (c == 8'd10) begin
          if (line_r != LineMax) line_nxt = line_r + 20'd1;
        end else if (c == "#") mode_nxt = M_COMMENT;
        else if (c == "\"") begin
          sst_nxt = (q_data.pos != PosMax) ? q_data.pos + 24'd1 : PosMax;
          slen_nxt = '0; kw_nxt = '1; acc_nxt = '0; mode_nxt = M_STRING;
        end else if (c == "=") mode_nxt = M_EQ;
        else if (c == "!") mode_nxt = M_BANG;
        else if (c == ">") mode_nxt = M_GT;
        else if (q_data.is_digit) begin
          sst_nxt = q_data.pos; slen_nxt = SpanW'(1); kw_nxt = '1;
          acc_nxt = 31'(c - 8'd48); mode_nxt = M_INT;
        end else if (q_data.is_alpha) begin
          sst_nxt = q_data.pos; slen_nxt = SpanW'(1); acc_nxt = '0;
          for (int k = 0; k < NumKw; k++) kw_nxt[k] = kw_char(k, 0) == c;
          mode_nxt = M_IDENT;
        end else begin
          priority case (c)
            ",": kind = KindComma;
            ":": kind = KindColon;
            ";": kind = KindSemi;
            "(": kind = KindLpar;
            ")": kind = KindRpar;
            "+": kind = KindAdd;
            "-": kind = KindSub;
            "*": kind = KindMul;
            "/": kind = KindDiv;
            "<": kind = KindLess;
            default: kind = '0;
          endcase
          res[nres[0]].line_number = line_nxt;
          if (kind == '0) begin
            res[nres[0]].token_kind = KindFinish;
            res[nres[0]].error_code = ErrUnknown;
            res[nres[0]].bad_char   = c;
            halt_nxt = 1'b1;
          end else if (tcnt_nxt >= TokCntW'(TokenLimit)) begin
            res[nres[0]].token_kind = KindFinish;
            res[nres[0]].error_code = ErrCount;
            halt_nxt = 1'b1;
          end else begin
            res[nres[0]].token_kind = kind;
            tcnt_nxt = tcnt_nxt + 1'b1;
          end
          nres = nres + 2'd1;
        end
      end
      if (nres != 2'd0) res[nres[1] ? 1 : 0].last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && nres != 2'd0) rb_r[rwp_r] <= res[0];
    if (take && nres == 2'd2) rb_r[~rwp_r] <= res[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; line_r <= 20'd1; tcnt_r <= '0; acc_r <= '0;
      sst_r <= '0; slen_r <= '0; kw_r <= '1; halt_r <= 1'b0;
      rwp_r <= 1'b0; rrp_r <= 1'b0; rcnt_r <= 2'd0;
    end else begin
      if (take) begin
        mode_r <= mode_nxt; line_r <= line_nxt; tcnt_r <= tcnt_nxt; acc_r <= acc_nxt;
        sst_r <= sst_nxt; slen_r <= slen_nxt; kw_r <= kw_nxt; halt_r <= halt_nxt;
        rwp_r <= rwp_r ^ nres[0];
      end
      if (out_pop && !out_empty) rrp_r <= ~rrp_r;
      rcnt_r <= rcnt_r + (take ? nres : 2'd0) - 2'(out_pop && !out_empty);
    end
  end

endmodule

FILE: hdl/source_text_tokenizer.sv
`timescale 1ns / 1ps
// Byte-stream tokenizer. Each transaction carries one source byte or the end
// marker; results come out of a two-entry output buffer as tokens with line,
// position and length. The front part numbers and classifies bytes into a
// two-entry queue; the back part runs the scanner and takes one byte per cycle
// whenever the output buffer is empty or holds one result that is popped in
// that cycle. With results popped every cycle one byte is accepted per cycle;
// a byte that gives two results stalls the intake while the buffer drains.
// After an error or the finish token no further results appear until reset.
module source_text_tokenizer
  import stt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic      q_push, q_full, q_pop, q_empty;
  cls_item_t q_wdata, q_rdata;

  stt_front u_front (
    .clk, .rst_n, .in_push(push), .in_full(full), .in_data(in_item),
    .q_push, .q_full, .q_data(q_wdata)
  );

  stt_queue u_queue (
    .clk, .rst_n, .push(q_push), .full(q_full), .wdata(q_wdata),
    .pop(q_pop), .empty(q_empty), .rdata(q_rdata)
  );

  stt_back u_back (
    .clk, .rst_n, .q_empty, .q_pop, .q_data(q_rdata),
    .out_empty(empty), .out_pop(pop), .out_data(out_item)
  );

endmodule

FILE: test/source_text_tokenizer_test.sv
`timescale 1ns / 1ps
module source_text_tokenizer_test;
  import stt_pkg::*;

  typedef struct {
    bit       drain;
    in_item_t byte_in;
  } src_entry_t;

  typedef enum int {
    EndFinish, EndUnknown, EndQuote, EndFraction, EndLong, EndCount
  } ending_e;

  localparam int unsigned IdleLimit = 20000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      full;
  in_item_t  in_item = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t out_item;

  source_text_tokenizer dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  src_entry_t  source_bytes[$];
  out_item_t   tokens_due[$];
  out_item_t   step_tokens[$];
  bit          next_drain;
  int unsigned bytes_taken, tokens_seen, mismatches, idle_cycles;
  int unsigned burst_left, gap_left, stall_cycle, stall_mode;
  bit          slot_go;
  ending_e     ending;

  string kw_word[12] = '{"int", "real", "str", "var", "if", "else", "while", "return",
                         "function", "end", "and", "or"};

  // Scanner state kept by the predictor.
  mode_t       sc_mode;
  logic [19:0] sc_line;
  logic [23:0] sc_pos;
  int unsigned sc_count;
  logic [30:0] sc_acc;
  logic [23:0] sc_start;
  int unsigned sc_len;
  logic [11:0] sc_kw;
  bit          sc_halt;

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_let(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic void emit_token(logic [5:0] k, logic [2:0] e, logic [30:0] v,
                                     logic [23:0] s, int unsigned l, logic [7:0] b);
    out_item_t r;
    r.token_kind = k;
    r.error_code = e;
    r.line_number = sc_line;
    r.int_value = v;
    r.text_start = s;
    r.text_length = l[5:0];
    r.bad_char = b;
    r.last_of_run = 1'b0;
    step_tokens.push_back(r);
  endfunction

  function automatic void raise_error(logic [2:0] e, logic [7:0] b);
    emit_token(KindFinish, e, '0, '0, 0, b);
    sc_halt = 1'b1;
    sc_mode = M_IDLE;
  endfunction

  function automatic bit count_exhausted();
    if (sc_count >= TokenLimit) begin
      raise_error(ErrCount, 8'd0);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void plain_token(logic [5:0] k);
    if (count_exhausted()) return;
    sc_count++;
    emit_token(k, ErrNone, '0, '0, 0, 8'd0);
  endfunction

  function automatic void text_token(logic [5:0] k, logic [30:0] v);
    if (count_exhausted()) return;
    if (sc_len > TextLimit) begin
      raise_error(ErrLong, 8'd0);
      return;
    end
    sc_count++;
    emit_token(k, ErrNone, v, sc_start, sc_len, 8'd0);
  endfunction

  function automatic void word_token();
    logic [5:0] k;
    k = KindId;
    if (sc_len > TextLimit) begin
      raise_error(ErrLong, 8'd0);
      return;
    end
    for (int i = 0; i < 12; i++)
      if (sc_kw[i] && kw_word[i].len() == sc_len) k = i[5:0];
    if (count_exhausted()) return;
    sc_count++;
    if (k == KindId) emit_token(k, ErrNone, '0, sc_start, sc_len, 8'd0);
    else emit_token(k, ErrNone, '0, '0, 0, 8'd0);
  endfunction

  function automatic void extend_span();
    if (sc_len <= TextLimit) sc_len++;
  endfunction

  function automatic void narrow_keywords(logic [7:0] c);
    for (int i = 0; i < 12; i++)
      if (sc_len >= kw_word[i].len() || kw_word[i][sc_len] != c) sc_kw[i] = 1'b0;
  endfunction

  function automatic void open_span(logic [23:0] s);
    sc_start = s;
    sc_len = 0;
    sc_kw = '1;
    sc_acc = '0;
  endfunction

  function automatic void close_pending();
    mode_t m;
    m = sc_mode;
    sc_mode = M_IDLE;
    case (m)
      M_INT:    text_token(KindInt, sc_acc);
      M_FRAC:   text_token(KindReal, '0);
      M_DOT:    raise_error(ErrFraction, 8'd0);
      M_STRING: raise_error(ErrQuote, 8'd0);
      M_IDENT:  word_token();
      M_EQ:     plain_token(KindAssign);
      M_BANG:   plain_token(KindNot);
      M_GT:     plain_token(KindGreater);
      default: ;
    endcase
  endfunction

  function automatic void start_byte(logic [7:0] c);
    case (c)
      " ", "\t", 8'd13: ;
      "\n": if (sc_line != LineMax) sc_line++;
      "#": sc_mode = M_COMMENT;
      "\"": begin
        open_span(sc_pos != PosMax ? sc_pos + 24'd1 : PosMax);
        sc_mode = M_STRING;
      end
      ",": plain_token(KindComma);
      ":": plain_token(KindColon);
      ";": plain_token(KindSemi);
      "(": plain_token(KindLpar);
      ")": plain_token(KindRpar);
      "+": plain_token(KindAdd);
      "-": plain_token(KindSub);
      "*": plain_token(KindMul);
      "/": plain_token(KindDiv);
      "<": plain_token(KindLess);
      "=": sc_mode = M_EQ;
      "!": sc_mode = M_BANG;
      ">": sc_mode = M_GT;
      default: begin
        if (is_dig(c)) begin
          open_span(sc_pos);
          sc_acc = 31'(c - "0");
          sc_len = 1;
          sc_mode = M_INT;
        end else if (is_let(c)) begin
          open_span(sc_pos);
          narrow_keywords(c);
          sc_len = 1;
          sc_mode = M_IDENT;
        end else begin
          raise_error(ErrUnknown, c);
        end
      end
    endcase
  endfunction

  function automatic void scan_byte(logic [7:0] c);
    longint unsigned v;
    case (sc_mode)
      M_COMMENT: begin
        if (c == "\n") begin
          sc_mode = M_IDLE;
          if (sc_line != LineMax) sc_line++;
        end
        return;
      end
      M_STRING: begin
        if (c == "\"") begin
          sc_mode = M_IDLE;
          text_token(KindStr, '0);
        end else extend_span();
        return;
      end
      M_INT: begin
        if (is_dig(c)) begin
          v = longint'(sc_acc) * 10 + (c - "0");
          sc_acc = v > ValMax ? ValMax : v[30:0];
          extend_span();
          return;
        end
        if (c == ".") begin
          sc_mode = M_DOT;
          extend_span();
          return;
        end
      end
      M_DOT: begin
        if (is_dig(c)) begin
          sc_mode = M_FRAC;
          extend_span();
        end else raise_error(ErrFraction, 8'd0);
        return;
      end
      M_FRAC: if (is_dig(c)) begin
        extend_span();
        return;
      end
      M_IDENT: if (is_let(c) || is_dig(c)) begin
        narrow_keywords(c);
        extend_span();
        return;
      end
      M_EQ: if (c == "=") begin
        sc_mode = M_IDLE;
        plain_token(KindEqual);
        return;
      end
      M_BANG: if (c == "=") begin
        sc_mode = M_IDLE;
        plain_token(KindNoteq);
        return;
      end
      M_GT: if (c == "=") begin
        sc_mode = M_IDLE;
        plain_token(KindGreatereq);
        return;
      end
      default: begin
        sc_mode = M_IDLE;
        start_byte(c);
        return;
      end
    endcase
    close_pending();
    if (!sc_halt) start_byte(c);
  endfunction

  function automatic void predict_tokens(in_item_t it);
    step_tokens.delete();
    if (sc_halt) return;
    if (it.end_of_text) begin
      close_pending();
      if (!sc_halt) begin
        plain_token(KindFinish);
        sc_halt = 1'b1;
      end
    end else begin
      scan_byte(it.char_code);
      if (sc_pos != PosMax) sc_pos++;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
    foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
  endfunction

  // Source text generation.
  task automatic put_byte(logic [7:0] c);
    src_entry_t e;
    e.drain = next_drain;
    e.byte_in.char_code = c;
    e.byte_in.end_of_text = 1'b0;
    next_drain = 1'b0;
    source_bytes.push_back(e);
  endtask

  task automatic put_end();
    src_entry_t e;
    e.drain = next_drain;
    e.byte_in.char_code = 8'($urandom);
    e.byte_in.end_of_text = 1'b1;
    next_drain = 1'b0;
    source_bytes.push_back(e);
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  function automatic logic [7:0] any_letter();
    int unsigned r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] any_wordchar();
    if ($urandom_range(0, 3) == 0) return 8'("0" + $urandom_range(0, 9));
    return any_letter();
  endfunction

  task automatic put_word(int unsigned n);
    put_byte(any_letter());
    for (int i = 1; i < n; i++) put_byte(any_wordchar());
  endtask

  task automatic put_digits(int unsigned n);
    for (int i = 0; i < n; i++) put_byte(8'("0" + $urandom_range(0, 9)));
  endtask

  task automatic put_string_body(int unsigned n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      c = 8'($urandom);
      if (c == "\"") c = 8'hA2;
      put_byte(c);
    end
  endtask

  // Returns 1 when the token may be followed directly by anything.
  task automatic put_token(output bit joinable);
    string ops[16] = '{",", ":", ";", "(", ")", "=", "==", "+", "-", "*", "/", "!",
                       "!=", "<", ">", ">="};
    string w;
    logic [7:0] c;
    int unsigned n;
    joinable = 1'b0;
    case ($urandom_range(0, 11))
      0, 1: put_text(kw_word[$urandom_range(0, 11)]);
      2: begin
        w = kw_word[$urandom_range(0, 11)];
        n = $urandom_range(1, w.len());
        put_text(w.substr(0, n - 1));
        if ($urandom_range(0, 1)) put_byte(any_wordchar());
      end
      3: put_word($urandom_range(0, 20) == 0 ? TextLimit : $urandom_range(1, 10));
      4: begin
        n = $urandom_range(0, 9);
        if (n == 0) put_text($urandom_range(0, 1) ? "2147483647" : "2147483648");
        else if (n == 1) put_digits($urandom_range(11, 20));
        else put_digits($urandom_range(1, 6));
      end
      5: begin
        put_digits($urandom_range(1, 4));
        put_byte(".");
        put_digits($urandom_range(1, 4));
      end
      6: begin
        put_byte("\"");
        put_string_body($urandom_range(0, 3) == 0 ? $urandom_range(0, 66) : $urandom_range(0, 8));
        put_byte("\"");
        joinable = 1'b1;
      end
      7: begin
        put_byte("#");
        for (int i = $urandom_range(0, 12); i > 0; i--) begin
          c = 8'($urandom);
          put_byte(c == "\n" ? 8'h8A : c);
        end
        put_byte("\n");
        joinable = 1'b1;
      end
      default: begin
        put_text(ops[$urandom_range(0, 15)]);
        joinable = 1'b1;
      end
    endcase
  endtask

  task automatic put_blank();
    case ($urandom_range(0, 5))
      0: put_byte("\t");
      1: put_byte(8'd13);
      2: put_byte("\n");
      default: put_byte(" ");
    endcase
  endtask

  task automatic put_ending();
    logic [7:0] c;
    case (ending)
      EndFinish: begin
        case ($urandom_range(0, 3))
          0: put_word(3);
          1: put_digits(3);
          2: put_byte(">");
          default: ;
        endcase
        put_end();
      end
      EndUnknown: begin
        case ($urandom_range(0, 3))
          0: c = 8'd0;
          1: c = 8'($urandom_range(128, 255));
          2: c = ".";
          default: c = "@";
        endcase
        put_byte(c);
      end
      EndQuote: begin
        put_byte("\"");
        put_string_body($urandom_range(0, 5));
        put_end();
      end
      EndFraction: begin
        put_digits(2);
        put_byte(".");
        if ($urandom_range(0, 1)) put_byte(" ");
        else put_end();
      end
      EndLong: begin
        case ($urandom_range(0, 2))
          0: put_word($urandom_range(TextLimit + 1, TextLimit + 8));
          1: put_digits($urandom_range(TextLimit + 1, TextLimit + 8));
          default: begin
            put_byte("\"");
            put_string_body($urandom_range(TextLimit + 1, TextLimit + 8));
            put_byte("\"");
          end
        endcase
        put_byte(" ");
      end
      default: for (int i = 0; i < TokenLimit + 8; i++) put_byte(";");
    endcase
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  // Sender: bursts of transactions separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      in_item <= '0;
      sc_mode = M_IDLE;
      sc_line = 20'd1;
      sc_pos = '0;
      sc_count = 0;
      sc_acc = '0;
      sc_start = '0;
      sc_len = 0;
      sc_kw = '1;
      sc_halt = 1'b0;
    end else begin
      if (push && !full) begin
        predict_tokens(in_item);
        bytes_taken++;
      end
      if (!(push && full)) begin
        slot_go = 1'b0;
        if (gap_left > 0) gap_left--;
        else if (source_bytes.size() > 0 &&
                 (!source_bytes[0].drain || tokens_due.size() == 0)) slot_go = 1'b1;
        if (slot_go) begin
          in_item <= source_bytes[0].byte_in;
          source_bytes.pop_front();
          push <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(0, 4) == 0 ? 200 : $urandom_range(1, 20);
            gap_left = $urandom_range(0, 6);
          end else burst_left--;
        end else push <= 1'b0;
      end
    end
  end

  // Receiver: compares each result with the oldest predicted token.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        tokens_seen++;
        if (tokens_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: %p", out_item);
        end else begin
          if (out_item.token_kind !== tokens_due[0].token_kind ||
              out_item.error_code !== tokens_due[0].error_code ||
              out_item.line_number !== tokens_due[0].line_number ||
              out_item.int_value !== tokens_due[0].int_value ||
              out_item.text_start !== tokens_due[0].text_start ||
              out_item.text_length !== tokens_due[0].text_length ||
              out_item.bad_char !== tokens_due[0].bad_char ||
              out_item.last_of_run !== tokens_due[0].last_of_run) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, actual %p", tokens_due[0], out_item);
          end
          tokens_due.pop_front();
        end
      end
      stall_cycle++;
      if (stall_cycle % 64 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        default: pop <= $urandom_range(0, 7) == 0;
      endcase
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no transaction for %0d cycles", IdleLimit);
        $display("[source_text_tokenizer] ERROR");
        $finish;
      end
    end
  end

  initial begin
    bit joinable;
    next_drain = 1'b0;
    ending = ending_e'($urandom_range(0, 5));
    // Directed opening: operators, keywords, saturating integer, real, strings, comment.
    put_text("if>=!=== \"\"2147483648 0.5#\200\n\"\377\n\"while<");
    next_drain = 1'b1;
    joinable = 1'b1;
    while (source_bytes.size() < (ending == EndCount ? 200 : 1000)) begin
      if (source_bytes.size() > 500 && source_bytes.size() < 520) next_drain = 1'b1;
      if (!joinable || $urandom_range(0, 2) != 0) put_blank();
      put_token(joinable);
    end
    put_ending();
    for (int i = 0; i < 5; i++) put_byte(8'($urandom));
    put_end();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (source_bytes.size() > 0 || push) @(posedge clk);
    while (tokens_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Tokenized %0d bytes into %0d checked results; run ended by %s.",
             bytes_taken, tokens_seen, ending.name());
    if (mismatches == 0 && tokens_due.size() == 0) begin
      $display("[source_text_tokenizer] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, tokens_due.size());
      $display("[source_text_tokenizer] ERROR");
    end
    $finish;
  end

endmodule

FILE: source_text_tokenizer.f
hdl/stt_pkg.sv
hdl/stt_front.sv
hdl/stt_queue.sv
hdl/stt_back.sv
hdl/source_text_tokenizer.sv
test/source_text_tokenizer_test.sv
